FILE: hdl/dcdc_pkg.sv
// Shared constants, register indexes and state type for the dark-column centroid block.
`timescale 1ns / 1ps
`default_nettype none

package dcdc_pkg;

    localparam int PIXEL_W      = 8;
    localparam int CENT_W       = 10;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_LIM_W    = 13;
    localparam int RATIO_W      = 8;
    localparam int RATIO_FRAC_W = 4;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam logic [CFG_DATA_W-1:0] RESET_ROWS  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RESET_COLS  = 11'd1024;
    localparam logic [RATIO_W-1:0]    RESET_RATIO = 8'd88;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RATIO = 2'd2;

    typedef enum logic [2:0] {
        ST_STREAM,
        ST_PEAK,
        ST_SELECT,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/dcdc_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dcdc_divider
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int QUO_W = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numerator,
    input  wire logic [DEN_W-1:0] denominator,
    output logic                  busy,
    output logic [QUO_W-1:0]      quotient
);

    localparam int W      = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [W-1:0]      rem_reg;
    logic [W-1:0]      rem_next;
    logic [W-1:0]      den_reg;
    logic [W-1:0]      den_next;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  quo_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        if (start)
        begin
            rem_next  = W'(numerator);
            den_next  = W'(denominator) << (QUO_W - 1);
            quo_next  = '0;
            step_next = STEP_W'(QUO_W);
        end
        else if (step_reg != '0)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_next = rem_reg - den_reg;
                quo_next = (quo_reg << 1) | QUO_W'(1);
            end
            else
            begin
                quo_next = quo_reg << 1;
            end
            den_next  = den_reg >> 1;
            step_next = step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy     = (step_reg != '0);
    assign quotient = quo_reg;

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("divider not busy after start");

    a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(QUO_W))
        else $error("divider step count out of range");

    a_quo_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> $stable(quotient))
        else $error("quotient changed while idle");

endmodule

`default_nettype wire

FILE: hdl/dense_column_dark_centroid.sv
// Top level: per-column dark-pixel statistics and frame-end centroid.
`timescale 1ns / 1ps
`default_nettype none

// Pixels of a frame stream in at one per cycle in raster order; each pixel is a
// read-modify-write of its column's entry in a single column memory with one read
// port. After the last pixel the block stops taking pixels while it walks that
// memory twice, once to find the peak dark count and once to sum the selected
// columns, and then divides; in_ready stays low through both walks over the one
// read port and through the bit-serial divide, and longer when the previous
// frame result has not been taken yet.
// The frame result sits in an output register, so the next frame can start
// streaming while it waits to be taken. Column entries need no clearing pass:
// row 0 of every frame overwrites them.
module dense_column_dark_centroid
    import dcdc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PIXEL_W-1:0]     pixel,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CENT_W-1:0]           centroid_x,
    output logic [CENT_W-1:0]           centroid_y,
    output logic                        found
);

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int COLN_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int SUM_W   = 2 * ROW_W;
    localparam int MUL_W   = CNT_W + RATIO_W;
    localparam int PROD_W  = COL_W + CNT_W;
    localparam int TOT_W   = $clog2(MAX_COLS * MAX_ROWS + 1);
    localparam int X_W     = COL_W + TOT_W;
    localparam int Y_W     = ROW_W + TOT_W;

    typedef struct packed {
        logic [CNT_W-1:0] dark;
        logic [CNT_W-1:0] inner;
        logic [SUM_W-1:0] sum;
    } entry_t;

    // configuration
    logic [CFG_DATA_W-1:0] rows_in_use_reg;
    logic [CFG_DATA_W-1:0] cols_in_use_reg;
    logic [RATIO_W-1:0]    ratio_reg;
    logic [CNT_W-1:0]      rows_eff;
    logic [COLN_W-1:0]     cols_eff;

    // control
    state_t            state_reg;
    state_t            state_next;
    logic [COL_W-1:0]  col_pos_reg;
    logic [COL_W-1:0]  col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg;
    logic [ROW_W-1:0]  row_pos_next;
    logic [CNT_W-1:0]  rows_frame_reg;
    logic [CNT_W-1:0]  rows_frame_next;
    logic [COLN_W-1:0] cols_frame_reg;
    logic [COLN_W-1:0] cols_frame_next;
    logic [COLN_W-1:0] walk_cnt_reg;
    logic [COLN_W-1:0] walk_cnt_next;
    logic [CNT_W-1:0]  peak_reg;
    logic [CNT_W-1:0]  peak_next;
    logic [X_W-1:0]    x_acc_reg;
    logic [X_W-1:0]    x_acc_next;
    logic [Y_W-1:0]    y_acc_reg;
    logic [Y_W-1:0]    y_acc_next;
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CENT_W-1:0] centroid_x_reg;
    logic [CENT_W-1:0] centroid_x_next;
    logic [CENT_W-1:0] centroid_y_reg;
    logic [CENT_W-1:0] centroid_y_next;
    logic              found_reg;
    logic              found_next;
    logic              walk_issue;
    logic              div_start;

    // pixel stage
    logic              accept;
    logic              last_col;
    logic              last_row;
    logic              pix_dark;
    logic              pix_inner;
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    logic              s1_dark_reg;
    logic              s1_first_reg;
    logic              s1_inner_reg;
    logic [ROW_W-1:0]  s1_row_reg;

    // column memory
    entry_t            mem [MAX_COLS];
    entry_t            rd_data_reg;
    entry_t            wr_entry;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;

    // walk stages
    logic              walk_rd_valid_reg;
    logic [COL_W-1:0]  walk_rd_idx_reg;
    logic              a_valid_reg;
    logic              a_sel_reg;
    logic [PROD_W-1:0] a_prod_reg;
    logic [SUM_W-1:0]  a_ysum_reg;
    logic [CNT_W-1:0]  a_inner_reg;
    logic              sel_now;

    // divider
    logic              x_busy;
    logic              y_busy;
    logic [COL_W-1:0]  x_quo;
    logic [ROW_W-1:0]  y_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= RESET_ROWS;
            cols_in_use_reg <= RESET_COLS;
            ratio_reg       <= RESET_RATIO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS:  rows_in_use_reg <= cfg_data;
                REG_COLS:  cols_in_use_reg <= cfg_data;
                REG_RATIO: ratio_reg       <= cfg_data[RATIO_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        if (rows_in_use_reg == '0)
            rows_eff = CNT_W'(1);
        else if (CFG_LIM_W'(rows_in_use_reg) > CFG_LIM_W'(MAX_ROWS))
            rows_eff = CNT_W'(MAX_ROWS);
        else
            rows_eff = CNT_W'(rows_in_use_reg);

        if (cols_in_use_reg == '0)
            cols_eff = COLN_W'(1);
        else if (CFG_LIM_W'(cols_in_use_reg) > CFG_LIM_W'(MAX_COLS))
            cols_eff = COLN_W'(MAX_COLS);
        else
            cols_eff = COLN_W'(cols_in_use_reg);
    end

    assign in_ready  = (state_reg == ST_STREAM);
    assign accept    = in_valid && in_ready;
    assign pix_dark  = (pixel == '0);
    assign last_col  = (COLN_W'(col_pos_reg) + COLN_W'(1)) >= cols_eff;
    assign last_row  = (CNT_W'(row_pos_reg) + CNT_W'(1)) >= rows_eff;
    assign pix_inner = pix_dark && (row_pos_reg != '0)
                       && ((CNT_W'(row_pos_reg) + CNT_W'(1)) != rows_eff);

    assign walk_issue = ((state_reg == ST_PEAK) || (state_reg == ST_SELECT))
                        && (walk_cnt_reg < cols_frame_reg);
    assign rd_en      = accept || walk_issue;
    assign rd_addr    = (state_reg == ST_STREAM) ? col_pos_reg : walk_cnt_reg[COL_W-1:0];

    always_comb
    begin
        if (s1_first_reg)
        begin
            wr_entry.dark  = CNT_W'(s1_dark_reg);
            wr_entry.inner = '0;
            wr_entry.sum   = '0;
        end
        else
        begin
            wr_entry.dark  = rd_data_reg.dark + CNT_W'(s1_dark_reg);
            wr_entry.inner = rd_data_reg.inner + CNT_W'(s1_inner_reg);
            wr_entry.sum   = rd_data_reg.sum + (s1_inner_reg ? SUM_W'(s1_row_reg) : SUM_W'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            mem[s1_addr_reg] <= wr_entry;
        if (rd_en)
        begin
            if (s1_valid_reg && (s1_addr_reg == rd_addr))
                rd_data_reg <= wr_entry;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign sel_now = (rd_data_reg.dark < rows_frame_reg)
                     && ((MUL_W'(rd_data_reg.dark) * MUL_W'(ratio_reg))
                         > (MUL_W'(peak_reg) << RATIO_FRAC_W));

    always_comb
    begin
        state_next      = state_reg;
        col_pos_next    = col_pos_reg;
        row_pos_next    = row_pos_reg;
        rows_frame_next = rows_frame_reg;
        cols_frame_next = cols_frame_reg;
        walk_cnt_next   = walk_cnt_reg;
        peak_next       = peak_reg;
        x_acc_next      = x_acc_reg;
        y_acc_next      = y_acc_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        centroid_x_next = centroid_x_reg;
        centroid_y_next = centroid_y_reg;
        found_next      = found_reg;
        div_start       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (walk_issue)
            walk_cnt_next = walk_cnt_reg + COLN_W'(1);

        case (state_reg)
            ST_STREAM:
            begin
                if (accept)
                begin
                    if (last_col)
                    begin
                        col_pos_next = '0;
                        if (last_row)
                        begin
                            row_pos_next    = '0;
                            rows_frame_next = rows_eff;
                            cols_frame_next = cols_eff;
                            walk_cnt_next   = '0;
                            peak_next       = '0;
                            state_next      = ST_PEAK;
                        end
                        else
                        begin
                            row_pos_next = row_pos_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_pos_next = col_pos_reg + COL_W'(1);
                    end
                end
            end
            ST_PEAK:
            begin
                if (walk_rd_valid_reg && (rd_data_reg.dark < rows_frame_reg)
                    && (rd_data_reg.dark > peak_reg))
                    peak_next = rd_data_reg.dark;
                if (!walk_issue && !walk_rd_valid_reg)
                begin
                    walk_cnt_next = '0;
                    x_acc_next    = '0;
                    y_acc_next    = '0;
                    total_next    = '0;
                    state_next    = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (a_valid_reg && a_sel_reg)
                begin
                    x_acc_next = x_acc_reg + X_W'(a_prod_reg);
                    y_acc_next = y_acc_reg + Y_W'(a_ysum_reg);
                    total_next = total_reg + TOT_W'(a_inner_reg);
                end
                if (!walk_issue && !walk_rd_valid_reg && !a_valid_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!x_busy && !y_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = (total_reg != '0);
                    if (total_reg != '0)
                    begin
                        centroid_x_next = CENT_W'(x_quo);
                        centroid_y_next = CENT_W'(y_quo);
                    end
                    else
                    begin
                        centroid_x_next = '0;
                        centroid_y_next = '0;
                    end
                    state_next = ST_STREAM;
                end
            end
            default:
            begin
                state_next = ST_STREAM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_STREAM;
            col_pos_reg       <= '0;
            row_pos_reg       <= '0;
            walk_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
            s1_valid_reg      <= 1'b0;
            walk_rd_valid_reg <= 1'b0;
            a_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            col_pos_reg       <= col_pos_next;
            row_pos_reg       <= row_pos_next;
            walk_cnt_reg      <= walk_cnt_next;
            out_valid_reg     <= out_valid_next;
            s1_valid_reg      <= accept;
            walk_rd_valid_reg <= walk_issue;
            a_valid_reg       <= walk_rd_valid_reg && (state_reg == ST_SELECT);
        end
    end

    always_ff @(posedge clk)
    begin
        rows_frame_reg  <= rows_frame_next;
        cols_frame_reg  <= cols_frame_next;
        peak_reg        <= peak_next;
        x_acc_reg       <= x_acc_next;
        y_acc_reg       <= y_acc_next;
        total_reg       <= total_next;
        centroid_x_reg  <= centroid_x_next;
        centroid_y_reg  <= centroid_y_next;
        found_reg       <= found_next;
        s1_addr_reg     <= col_pos_reg;
        s1_dark_reg     <= pix_dark;
        s1_first_reg    <= (row_pos_reg == '0);
        s1_inner_reg    <= pix_inner;
        s1_row_reg      <= row_pos_reg;
        walk_rd_idx_reg <= walk_cnt_reg[COL_W-1:0];
        a_sel_reg       <= sel_now;
        a_prod_reg      <= PROD_W'(walk_rd_idx_reg) * PROD_W'(rd_data_reg.inner);
        a_ysum_reg      <= rd_data_reg.sum;
        a_inner_reg     <= rd_data_reg.inner;
    end

    dcdc_divider
    #(
        .NUM_W (X_W),
        .DEN_W (TOT_W),
        .QUO_W (COL_W)
    )
    u_x_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (x_acc_reg),
        .denominator (total_reg),
        .busy        (x_busy),
        .quotient    (x_quo)
    );

    dcdc_divider
    #(
        .NUM_W (Y_W),
        .DEN_W (TOT_W),
        .QUO_W (ROW_W)
    )
    u_y_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (y_acc_reg),
        .denominator (total_reg),
        .busy        (y_busy),
        .quotient    (y_quo)
    );

    assign out_valid  = out_valid_reg;
    assign centroid_x = centroid_x_reg;
    assign centroid_y = centroid_y_reg;
    assign found      = found_reg;

    a_pixel_walk_excl : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !walk_rd_valid_reg)
        else $error("pixel update and column walk share the read data");

    a_frame_end : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col && last_row) |=> (state_reg == ST_PEAK))
        else $error("last pixel did not start the column walk");

    a_divide_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (!a_valid_reg && !walk_rd_valid_reg && !s1_valid_reg))
        else $error("walk pipeline active during divide");

    a_emit_loads : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("frame result not presented");

    a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> ((centroid_x_reg == '0) && (centroid_y_reg == '0)))
        else $error("centroid fields nonzero without a centroid");

endmodule

`default_nettype wire

FILE: test/tb_dense_column_dark_centroid.sv
// Testbench for the dark-column centroid block: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_dense_column_dark_centroid;

    import dcdc_pkg::*;

    localparam int MAX_COLS         = DEF_MAX_COLS;
    localparam int MAX_ROWS         = DEF_MAX_ROWS;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int LONG_HOLD_CYCLES = 600;

    typedef struct packed {
        logic [CENT_W-1:0] x;
        logic [CENT_W-1:0] y;
        logic              found;
    } centroid_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [PIXEL_W-1:0]     pixel = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CENT_W-1:0]      centroid_x;
    logic [CENT_W-1:0]      centroid_y;
    logic                   found;

    // register copies and per-column frame statistics of the predictor
    logic [CFG_DATA_W-1:0]  rows_reg = RESET_ROWS;
    logic [CFG_DATA_W-1:0]  cols_reg = RESET_COLS;
    logic [RATIO_W-1:0]     ratio_reg = RESET_RATIO;
    int unsigned            dark_count [MAX_COLS];
    int unsigned            inner_count [MAX_COLS];
    int unsigned            row_sum [MAX_COLS];
    int unsigned            row_pos = 0;
    int unsigned            col_pos = 0;

    logic [PIXEL_W-1:0]     pending_pixels [$];
    centroid_t              expected_centroids [$];
    centroid_t              oldest_frame;

    int unsigned            pixels_queued = 0;
    int unsigned            pixels_accepted = 0;
    int unsigned            frames_checked = 0;
    int unsigned            frames_found = 0;
    int unsigned            settings_count = 0;
    int unsigned            mismatches = 0;
    int unsigned            quiet_cycles;
    int unsigned            send_gap = 0;
    int unsigned            ready_gap = 0;
    int unsigned            hold_left = 0;
    bit                     hold_started = 1'b0;
    bit                     hold_arm = 1'b0;
    bit                     idle_en = 1'b1;

    dense_column_dark_centroid u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .centroid_x (centroid_x),
        .centroid_y (centroid_y),
        .found      (found)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned effective_size(input logic [CFG_DATA_W-1:0] value,
                                                   input int unsigned cap);
        if (value == '0)
            return 1;
        return (value > cap) ? cap : int'(value);
    endfunction

    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t ns, frame %0d: %s", $time, frames_checked, msg);
    endtask

    task automatic accumulate_pixel(input logic [PIXEL_W-1:0] value);
        int unsigned     rows_n;
        int unsigned     cols_n;
        int unsigned     peak;
        int unsigned     col;
        longint unsigned sum_x;
        longint unsigned sum_y;
        longint unsigned total;
        bit              dark;
        centroid_t       frame_result;
        rows_n = effective_size(rows_reg, MAX_ROWS);
        cols_n = effective_size(cols_reg, MAX_COLS);
        dark = (value == '0);
        if (row_pos == 0)
        begin
            dark_count[col_pos] = dark;
            inner_count[col_pos] = 0;
            row_sum[col_pos] = 0;
        end
        else
        begin
            if (dark)
                dark_count[col_pos]++;
            if (dark && row_pos + 1 != rows_n)
            begin
                inner_count[col_pos]++;
                row_sum[col_pos] += row_pos;
            end
        end
        if (col_pos + 1 >= cols_n)
        begin
            col_pos = 0;
            if (row_pos + 1 >= rows_n)
            begin
                row_pos = 0;
                peak = 0;
                for (col = 0; col < cols_n; col++)
                    if (dark_count[col] < rows_n && dark_count[col] > peak)
                        peak = dark_count[col];
                sum_x = 0;
                sum_y = 0;
                total = 0;
                for (col = 0; col < cols_n; col++)
                begin
                    if (dark_count[col] < rows_n &&
                        64'(dark_count[col]) * ratio_reg > 64'(peak) * 16)
                    begin
                        sum_x += 64'(col) * inner_count[col];
                        sum_y += row_sum[col];
                        total += inner_count[col];
                    end
                end
                frame_result.found = (total != 0);
                frame_result.x = (total != 0) ? CENT_W'(sum_x / total) : '0;
                frame_result.y = (total != 0) ? CENT_W'(sum_y / total) : '0;
                expected_centroids.push_back(frame_result);
            end
            else
                row_pos++;
        end
        else
            col_pos++;
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accumulate_pixel(pixel);
                pixels_accepted++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_pixels.size() != 0)
                begin
                    in_valid <= 1'b1;
                    pixel <= pending_pixels.pop_front();
                    if (idle_en)
                        send_gap <= gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
            hold_started <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_centroids.size() == 0)
                    report_mismatch($sformatf("result with no frame pending: x=%0d y=%0d found=%0b",
                                              centroid_x, centroid_y, found));
                else
                begin
                    oldest_frame = expected_centroids.pop_front();
                    if (found !== oldest_frame.found)
                        report_mismatch($sformatf("found got %0b expected %0b",
                                                  found, oldest_frame.found));
                    if (centroid_x !== oldest_frame.x)
                        report_mismatch($sformatf("centroid_x got %0d expected %0d",
                                                  centroid_x, oldest_frame.x));
                    if (centroid_y !== oldest_frame.y)
                        report_mismatch($sformatf("centroid_y got %0d expected %0d",
                                                  centroid_y, oldest_frame.y));
                    frames_checked++;
                    if (oldest_frame.found)
                        frames_found++;
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_arm && !hold_started)
            begin
                hold_started <= 1'b1;
                hold_left <= LONG_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (ready_gap != 0)
            begin
                out_ready <= 1'b0;
                ready_gap <= ready_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_en)
                    ready_gap <= gap_len();
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic queue_pixel(input logic [PIXEL_W-1:0] value);
        pending_pixels.push_back(value);
        pixels_queued++;
    endtask

    task automatic settle();
        while (pixels_accepted != pixels_queued || expected_centroids.size() != 0)
            @(posedge clk);
        repeat (2 * effective_size(cols_reg, MAX_COLS) + 64) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROWS:  rows_reg = value;
            REG_COLS:  cols_reg = value;
            REG_RATIO: ratio_reg = value[RATIO_W-1:0];
            default:   ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] rows_val,
                                  input logic [CFG_DATA_W-1:0] cols_val,
                                  input logic [RATIO_W-1:0] ratio_val);
        settle();
        write_reg(REG_ROWS, rows_val);
        write_reg(REG_COLS, cols_val);
        write_reg(REG_RATIO, CFG_DATA_W'(ratio_val));
        settings_count++;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] rows_val,
                             input logic [CFG_DATA_W-1:0] cols_val,
                             input logic [RATIO_W-1:0] ratio_val,
                             input int unsigned frames,
                             input bit no_idle,
                             input bit with_hold);
        int unsigned rows_n;
        int unsigned cols_n;
        int unsigned r_idx;
        int unsigned c_idx;
        int unsigned roll;
        int unsigned density [MAX_COLS];
        apply_settings(rows_val, cols_val, ratio_val);
        rows_n = effective_size(rows_reg, MAX_ROWS);
        cols_n = effective_size(cols_reg, MAX_COLS);
        idle_en = !no_idle;
        if (with_hold)
            hold_arm = 1'b1;
        repeat (frames)
        begin
            for (c_idx = 0; c_idx < cols_n; c_idx++)
            begin
                roll = $urandom_range(0, 9);
                density[c_idx] = (roll == 0) ? 100 : (roll == 1) ? 0 : $urandom_range(0, 100);
            end
            for (r_idx = 0; r_idx < rows_n; r_idx++)
            begin
                for (c_idx = 0; c_idx < cols_n; c_idx++)
                begin
                    roll = $urandom_range(0, 7);
                    if ($urandom_range(0, 99) < density[c_idx])
                        queue_pixel('0);
                    else if (roll == 0)
                        queue_pixel(8'hFF);
                    else if (roll == 1)
                        queue_pixel(8'h01);
                    else
                        queue_pixel(PIXEL_W'($urandom_range(1, 255)));
                end
            end
        end
    endtask

    initial
    begin
        int unsigned            phase;
        int unsigned            roll;
        logic [CFG_DATA_W-1:0]  rows_val;
        logic [CFG_DATA_W-1:0]  cols_val;
        logic [RATIO_W-1:0]     ratio_val;
        logic [PIXEL_W-1:0]     grid [9];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // single-pixel frames: a fully dark column never counts
        apply_settings(11'd1, 11'd1, 8'd88);
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        // zero sizes act as one
        apply_settings(11'd0, 11'd0, 8'd88);
        queue_pixel(8'd0);
        queue_pixel(8'd1);
        // one interior dark pixel, a full column excluded, a bottom-row dark pixel
        apply_settings(11'd3, 11'd3, 8'd88);
        grid = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd254, 8'd1, 8'd0, 8'd0};
        foreach (grid[k])
            queue_pixel(grid[k]);
        // zero ratio selects nothing
        apply_settings(11'd4, 11'd1, 8'd0);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        // single row: every dark pixel sits in the top row
        apply_settings(11'd1, 11'd4, 8'd255);
        queue_pixel(8'd0);
        queue_pixel(8'd0);
        queue_pixel(8'd0);
        queue_pixel(8'd127);

        for (phase = 0; phase < 8; phase++)
        begin
            roll = $urandom_range(0, 19);
            rows_val = (roll == 0) ? 11'd0 : (roll == 1) ? 11'd1 : 11'($urandom_range(2, 8));
            roll = $urandom_range(0, 19);
            cols_val = (roll == 0) ? 11'd0 : (roll == 1) ? 11'd1 : 11'($urandom_range(2, 8));
            roll = $urandom_range(0, 9);
            case (roll)
                0:       ratio_val = 8'd0;
                1:       ratio_val = 8'd1;
                2:       ratio_val = 8'd16;
                3:       ratio_val = 8'd17;
                4:       ratio_val = 8'd255;
                5:       ratio_val = 8'd88;
                default: ratio_val = RATIO_W'($urandom_range(1, 255));
            endcase
            run_phase(rows_val, cols_val, ratio_val, 2, $urandom_range(0, 3) == 0, 1'b0);
        end

        run_phase(11'd3, 11'd3, 8'd88, 12, 1'b1, 1'b1);
        run_phase(11'd2047, 11'd1, 8'd255, 1, 1'b0, 1'b0);
        run_phase(11'd6, 11'd5, 8'd40, 2, 1'b0, 1'b0);

        settle();
        if (expected_centroids.size() != 0)
            report_mismatch($sformatf("%0d frame results never arrived", expected_centroids.size()));

        $display("Checked %0d frame results (%0d with a centroid) from %0d pixels",
                 frames_checked, frames_found, pixels_accepted);
        $display("over %0d register settings, frames from 1x1 up to a saturated 1024 rows",
                 settings_count);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dcdc_pkg.sv
hdl/dcdc_divider.sv
hdl/dense_column_dark_centroid.sv
test/tb_dense_column_dark_centroid.sv
